FILE: rtl/msa_pkg.sv
// Shared types and constants for the multi-channel sequence aligner.
// Used by msa_front, msa_back and the top level; no dependencies.
`default_nettype none

package msa_pkg;

  localparam int SEQ_W       = 31;
  localparam int PAY_PORT_W  = 32;
  localparam int CHAN_PORT_W = 3;
  localparam int CFG_W       = 4;
  localparam int MAX_ACTIVE  = 8;
  localparam int CNT_W       = 4;   // channel counter, holds 0..MAX_ACTIVE

  localparam int DEF_MAX_CHANNELS  = 8;
  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  localparam int CMDQ_DEPTH = 2;

  localparam logic [CFG_W-1:0] CAMERA_COUNT_RESET = 4'd2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic KIND_BUNDLE = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [CHAN_PORT_W-1:0] channel;
    logic [SEQ_W-1:0]       seq;
    logic [PAY_PORT_W-1:0]  payload;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/msa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module msa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: rtl/msa_front.sv
// Front end: accepts requests, drops pushes to missing channels, masks payload
// and queues commands for the back end. Depends on msa_pkg.
`default_nettype none

module msa_front #(
  parameter int MAX_CHANNELS  = msa_pkg::DEF_MAX_CHANNELS,
  parameter int PAYLOAD_WIDTH = msa_pkg::DEF_PAYLOAD_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               mode,
  input  wire logic [msa_pkg::CHAN_PORT_W-1:0]    channel,
  input  wire logic [msa_pkg::SEQ_W-1:0]          seq,
  input  wire logic [msa_pkg::PAY_PORT_W-1:0]     payload,
  output logic                                    cmd_valid,
  output msa_pkg::cmd_t                           cmd,
  input  wire logic                               cmd_pop
);

  localparam int QPTR_W = $clog2(msa_pkg::CMDQ_DEPTH);
  localparam int QCNT_W = $clog2(msa_pkg::CMDQ_DEPTH + 1);
  localparam logic [msa_pkg::PAY_PORT_W-1:0] PAY_MASK =
    msa_pkg::PAY_PORT_W'((64'd1 << PAYLOAD_WIDTH) - 64'd1);

  msa_pkg::cmd_t     q [msa_pkg::CMDQ_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic accept;
  logic chan_ok;
  logic push;
  logic pop;

  assign busy    = (count == QCNT_W'(msa_pkg::CMDQ_DEPTH));
  assign accept  = start && !busy;
  assign chan_ok = (32'(channel) < MAX_CHANNELS);
  // a push to a channel that does not exist is taken and forgotten
  assign push    = accept && ((mode == msa_pkg::MODE_TICK) || chan_ok);
  assign pop     = cmd_pop && cmd_valid;

  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].op      <= mode;
      q[wr_ptr].channel <= channel;
      q[wr_ptr].seq     <= seq;
      q[wr_ptr].payload <= payload & PAY_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(msa_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(msa_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/msa_back.sv
// Back end: per-channel FIFOs in one RAM, push/overflow handling and the
// tick scan/pop passes. Depends on msa_pkg and msa_ram.
`default_nettype none

module msa_back #(
  parameter int MAX_CHANNELS  = msa_pkg::DEF_MAX_CHANNELS,
  parameter int QUEUE_DEPTH   = msa_pkg::DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_WIDTH = msa_pkg::DEF_PAYLOAD_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [msa_pkg::CFG_W-1:0]         camera_count,
  input  wire logic                              cmd_valid,
  input  wire msa_pkg::cmd_t                     cmd,
  output logic                                   cmd_pop,
  output logic                                   strobe,
  output logic                                   kind,
  output logic [msa_pkg::CHAN_PORT_W-1:0]        out_channel,
  output logic [msa_pkg::SEQ_W-1:0]              out_seq,
  output logic [msa_pkg::PAY_PORT_W-1:0]         out_payload,
  output logic                                   last
);

  localparam int CH_W      = $clog2(MAX_CHANNELS);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W   = msa_pkg::SEQ_W + PAYLOAD_WIDTH;
  localparam int RAM_DEPTH = MAX_CHANNELS * (2 ** PTR_W);
  localparam int CAP       = (MAX_CHANNELS < msa_pkg::MAX_ACTIVE) ?
                             MAX_CHANNELS : msa_pkg::MAX_ACTIVE;
  localparam int CNT_W     = msa_pkg::CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PASS = 2'd2;

  logic [1:0]        state;
  logic [PTR_W-1:0]  rp   [MAX_CHANNELS];
  logic [PTR_W-1:0]  wp   [MAX_CHANNELS];
  logic [FILL_W-1:0] fill [MAX_CHANNELS];

  logic [CNT_W-1:0]         ich;      // channel whose head is being read
  logic [CNT_W-1:0]         dch;      // channel whose head is on rdata
  logic                     dval;
  logic [msa_pkg::SEQ_W-1:0] ref_seq;
  logic [msa_pkg::SEQ_W-1:0] adv;
  logic                     has_adv;
  logic                     has_del;
  logic                     all_eq;
  logic [msa_pkg::SEQ_W-1:0] bound;

  logic [CNT_W-1:0] n_act;
  logic             any_empty;
  logic [CH_W-1:0]  push_ch;
  logic             push_full;
  logic [CH_W-1:0]  rd_idx;
  logic [CH_W-1:0]  d_idx;
  logic             issue;
  logic             d_last;

  logic                      ram_we;
  logic [CH_W+PTR_W-1:0]     ram_addr;
  logic [ENTRY_W-1:0]        ram_wdata;
  logic [ENTRY_W-1:0]        ram_rdata;
  logic [msa_pkg::SEQ_W-1:0] h_seq;
  logic [PAYLOAD_WIDTH-1:0]  h_pay;

  logic                      scan_adv_next;
  logic                      scan_del_next;
  logic [msa_pkg::SEQ_W-1:0] scan_adv_max;
  logic                      scan_done;
  logic                      scan_end;
  logic                      strobe_next;

  msa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign h_seq = ram_rdata[ENTRY_W-1:PAYLOAD_WIDTH];
  assign h_pay = ram_rdata[PAYLOAD_WIDTH-1:0];

  always_comb begin
    if (camera_count == '0) begin
      n_act = CNT_W'(1);
    end else if (camera_count > CNT_W'(CAP)) begin
      n_act = CNT_W'(CAP);
    end else begin
      n_act = camera_count;
    end
  end

  always_comb begin
    any_empty = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      if ((CNT_W'(i) < n_act) && (fill[i] == '0)) begin
        any_empty = 1'b1;
      end
    end
  end

  assign push_ch   = CH_W'(cmd.channel);
  assign push_full = (fill[push_ch] == FILL_W'(QUEUE_DEPTH));
  assign issue     = (ich < n_act);
  assign rd_idx    = issue ? CH_W'(ich) : '0;
  assign d_idx     = CH_W'(dch);
  assign d_last    = (dch == n_act - 1'b1);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {rd_idx, rp[rd_idx]};
    ram_wdata = {cmd.seq, cmd.payload[PAYLOAD_WIDTH-1:0]};
    if (state == S_IDLE) begin
      ram_addr = {push_ch, wp[push_ch]};
      ram_we   = cmd_valid && (cmd.op == msa_pkg::MODE_PUSH) && !push_full;
    end
  end

  // head comparison against channel 0, stops at the last active channel or once both directions are seen
  always_comb begin
    scan_adv_next = has_adv;
    scan_del_next = has_del;
    scan_adv_max  = adv;
    if (dch != '0) begin
      if (h_seq > ref_seq) begin
        scan_adv_next = 1'b1;
        if (h_seq > adv) begin
          scan_adv_max = h_seq;
        end
      end else if (h_seq < ref_seq) begin
        scan_del_next = 1'b1;
      end
    end else begin
      scan_adv_next = 1'b0;
      scan_del_next = 1'b0;
      scan_adv_max  = h_seq;
    end
    scan_done = d_last || (scan_adv_next && scan_del_next);
  end

  assign scan_end    = (state == S_SCAN) && dval && scan_done;
  assign strobe_next = ((state == S_IDLE) && cmd_valid &&
                        (cmd.op == msa_pkg::MODE_PUSH) && push_full) ||
                       ((state == S_PASS) && dval && all_eq);

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      strobe  <= 1'b0;
      ich     <= '0;
      dch     <= '0;
      dval    <= 1'b0;
      has_adv <= 1'b0;
      has_del <= 1'b0;
      all_eq  <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        rp[i]   <= '0;
        wp[i]   <= '0;
        fill[i] <= '0;
      end
    end else begin
      strobe <= strobe_next;
      // head read pipeline; restarted from channel 0 when the scan ends
      if ((state != S_IDLE) && !scan_end) begin
        if (issue) begin
          ich  <= ich + 1'b1;
          dch  <= ich;
          dval <= 1'b1;
        end else begin
          dval <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == msa_pkg::MODE_PUSH) begin
              if (!push_full) begin
                wp[push_ch]   <= (wp[push_ch] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : wp[push_ch] + 1'b1;
                fill[push_ch] <= fill[push_ch] + 1'b1;
              end
            end else if (!any_empty) begin
              state   <= S_SCAN;
              ich     <= '0;
              dval    <= 1'b0;
              has_adv <= 1'b0;
              has_del <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (dval) begin
            has_adv <= scan_adv_next;
            has_del <= scan_del_next;
            adv     <= scan_adv_max;
            if (dch == '0) begin
              ref_seq <= h_seq;
            end
            if (scan_done) begin
              state  <= S_PASS;
              ich    <= '0;
              dval   <= 1'b0;
              all_eq <= !scan_adv_next && !scan_del_next;
              bound  <= scan_adv_next ? scan_adv_max :
                        ((dch == '0) ? h_seq : ref_seq);
            end
          end
        end
        S_PASS: begin
          if (dval) begin
            if (all_eq || (h_seq < bound)) begin
              rp[d_idx]   <= (rp[d_idx] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp[d_idx] + 1'b1;
              fill[d_idx] <= fill[d_idx] - 1'b1;
            end
            if (d_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      kind        <= msa_pkg::KIND_NOTICE;
      out_channel <= cmd.channel;
      out_seq     <= cmd.seq;
      out_payload <= cmd.payload;
      last        <= 1'b1;
    end else begin
      kind        <= msa_pkg::KIND_BUNDLE;
      out_channel <= msa_pkg::CHAN_PORT_W'(dch);
      out_seq     <= h_seq;
      out_payload <= msa_pkg::PAY_PORT_W'(h_pay);
      last        <= d_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/multi_channel_sequence_aligner_core.sv
// Multi-channel sequence aligner. Push: a notice (if the queue is full) follows
// the request through the command queue and the strobe register. Tick: no scan
// if an active queue is empty, else two pipelined passes (scan, then pop) over
// the single RAM read port; bundle members come on consecutive cycles.
// busy rises while the 2-entry command queue is full. Synchronous reset clears
// pointers, counts and control; queue RAM contents are not cleared.
`default_nettype none

module multi_channel_sequence_aligner_core #(
  parameter int MAX_CHANNELS  = msa_pkg::DEF_MAX_CHANNELS,
  parameter int QUEUE_DEPTH   = msa_pkg::DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_WIDTH = msa_pkg::DEF_PAYLOAD_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              mode,
  input  wire logic [msa_pkg::CHAN_PORT_W-1:0]   channel,
  input  wire logic [msa_pkg::SEQ_W-1:0]         seq,
  input  wire logic [msa_pkg::PAY_PORT_W-1:0]    payload,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [msa_pkg::CFG_W-1:0]         cfg_data,
  output logic                                   strobe,
  output logic                                   kind,
  output logic [msa_pkg::CHAN_PORT_W-1:0]        out_channel,
  output logic [msa_pkg::SEQ_W-1:0]              out_seq,
  output logic [msa_pkg::PAY_PORT_W-1:0]         out_payload,
  output logic                                   last
);

  logic [msa_pkg::CFG_W-1:0] camera_count;
  logic                      cmd_valid;
  msa_pkg::cmd_t             cmd;
  logic                      cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_count <= msa_pkg::CAMERA_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      camera_count <= cfg_data;
    end
  end

  msa_front #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .channel   (channel),
    .seq       (seq),
    .payload   (payload),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  msa_back #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .camera_count (camera_count),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .strobe       (strobe),
    .kind         (kind),
    .out_channel  (out_channel),
    .out_seq      (out_seq),
    .out_payload  (out_payload),
    .last         (last)
  );

`ifndef SYNTHESIS
  // overflow notices are single results
  a_notice_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == msa_pkg::KIND_NOTICE) |-> last)
    else $error("notice without last");

  // bundle members follow each other without gaps
  a_bundle_contig: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && (kind == msa_pkg::KIND_BUNDLE))
    else $error("bundle broken");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !busy && !strobe)
    else $error("activity right after reset");
`endif

endmodule

`default_nettype wire

FILE: test/tb_multi_channel_sequence_aligner_core.sv
`timescale 1ns / 1ps
// Testbench for multi_channel_sequence_aligner_core: drives push and tick requests,
// predicts queue contents, bundles and overflow notices, and checks every output.
// Depends on msa_pkg and the core RTL only.

module tb_multi_channel_sequence_aligner_core;

  localparam int FIFO_CH         = msa_pkg::DEF_MAX_CHANNELS;
  localparam int FIFO_DEPTH      = msa_pkg::DEF_QUEUE_DEPTH;
  localparam int SETTLE_CYCLES   = 80;   // room for three ticks in flight, with margin
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int PHASE_COUNT     = 7;
  localparam int PHASE_REQUESTS  = 30;

  typedef logic [msa_pkg::SEQ_W-1:0]       seq_t;
  typedef logic [msa_pkg::PAY_PORT_W-1:0]  pay_t;
  typedef logic [msa_pkg::CHAN_PORT_W-1:0] chan_t;
  typedef logic [msa_pkg::CFG_W-1:0]       count_t;

  typedef struct packed {
    logic  kind;
    chan_t chan;
    seq_t  seq;
    pay_t  pay;
    logic  last;
  } aligner_out_t;

  class align_scoreboard_t;
    seq_t         fifo_seq [FIFO_CH][FIFO_DEPTH];
    pay_t         fifo_pay [FIFO_CH][FIFO_DEPTH];
    int unsigned  rd_ptr [FIFO_CH];
    int unsigned  wr_ptr [FIFO_CH];
    int unsigned  fill [FIFO_CH];
    count_t       camera_count;
    aligner_out_t due_outputs [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  bundles;
    int unsigned  notices;

    function new();
      camera_count = msa_pkg::CAMERA_COUNT_RESET;
      foreach (fill[i]) begin
        rd_ptr[i] = 0;
        wr_ptr[i] = 0;
        fill[i] = 0;
      end
      mismatches = 0;
      checked = 0;
      bundles = 0;
      notices = 0;
    endfunction

    function void note_config(count_t v);
      camera_count = v;
    endfunction

    function int unsigned active_count();
      int unsigned n;
      n = 32'(camera_count);
      if (n < 1) n = 1;
      if (n > msa_pkg::MAX_ACTIVE) n = msa_pkg::MAX_ACTIVE;
      return n;
    endfunction

    function int unsigned outstanding();
      return due_outputs.size();
    endfunction

    function void pop_head(int unsigned c);
      rd_ptr[c] = (rd_ptr[c] + 1) % FIFO_DEPTH;
      fill[c]--;
    endfunction

    // Apply one accepted request to the queue image; queue the outputs it causes.
    function void predict(logic m, chan_t ch, seq_t s, pay_t p);
      int unsigned  n, i, c;
      seq_t         anchor, newest, bound, h;
      bit           saw_later, saw_earlier;
      aligner_out_t r;
      c = 32'(ch);
      if (m == msa_pkg::MODE_PUSH) begin
        if (fill[c] >= FIFO_DEPTH) begin
          r.kind = msa_pkg::KIND_NOTICE;
          r.chan = ch;
          r.seq  = s;
          r.pay  = p;
          r.last = 1'b1;
          due_outputs.insert(due_outputs.size(), r);
          notices++;
          return;
        end
        fifo_seq[c][wr_ptr[c]] = s;
        fifo_pay[c][wr_ptr[c]] = p;
        wr_ptr[c] = (wr_ptr[c] + 1) % FIFO_DEPTH;
        fill[c]++;
        return;
      end
      n = active_count();
      for (i = 0; i < n; i++)
        if (fill[i] == 0) return;
      anchor = fifo_seq[0][rd_ptr[0]];
      newest = anchor;
      saw_later = 1'b0;
      saw_earlier = 1'b0;
      for (i = 1; i < n; i++) begin
        h = fifo_seq[i][rd_ptr[i]];
        if (h > anchor) begin
          saw_later = 1'b1;
          if (h > newest) newest = h;
        end else if (h < anchor) begin
          saw_earlier = 1'b1;
        end
        // scan stops once both directions are seen; later heads past here are ignored
        if (saw_later && saw_earlier) break;
      end
      if (!saw_later && !saw_earlier) begin
        for (i = 0; i < n; i++) begin
          r.kind = msa_pkg::KIND_BUNDLE;
          r.chan = chan_t'(i);
          r.seq  = fifo_seq[i][rd_ptr[i]];
          r.pay  = fifo_pay[i][rd_ptr[i]];
          r.last = (i + 1 == n);
          due_outputs.insert(due_outputs.size(), r);
          pop_head(i);
        end
        bundles++;
        return;
      end
      bound = saw_later ? newest : anchor;
      for (i = 0; i < n; i++)
        if (fifo_seq[i][rd_ptr[i]] < bound) pop_head(i);
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(logic k, chan_t c, seq_t s, pay_t p, logic l);
      aligner_out_t want;
      checked++;
      if (due_outputs.size() == 0) begin
        report($sformatf("unexpected output kind %0d ch %0d seq %0h pay %0h", k, c, s, p));
        return;
      end
      want = due_outputs.pop_front();
      if (k !== want.kind || c !== want.chan || s !== want.seq || p !== want.pay
          || l !== want.last)
        report($sformatf("got kind %0d ch %0d seq %0h pay %0h last %0d, want %0d %0d %0h %0h %0d",
                         k, c, s, p, l, want.kind, want.chan, want.seq, want.pay, want.last));
    endtask

    task close_out();
      aligner_out_t want;
      while (due_outputs.size() != 0) begin
        want = due_outputs.pop_front();
        report($sformatf("missing output kind %0d ch %0d seq %0h", want.kind, want.chan, want.seq));
      end
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   mode = msa_pkg::MODE_PUSH;
  chan_t  channel = '0;
  seq_t   seq = '0;
  pay_t   payload = '0;
  logic   cfg_valid = 1'b0;
  count_t cfg_data = msa_pkg::CAMERA_COUNT_RESET;
  logic   busy;
  logic   cfg_ready;
  logic   strobe;
  logic   kind;
  chan_t  out_channel;
  seq_t   out_seq;
  pay_t   out_payload;
  logic   last;

  align_scoreboard_t sb = new();
  bit          gaps_on = 1'b1;
  bit          gap_burst = 1'b1;
  seq_t        frame_seq = 31'd16;
  int unsigned requests_sent = 0;

  multi_channel_sequence_aligner_core uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .channel     (channel),
    .seq         (seq),
    .payload     (payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .kind        (kind),
    .out_channel (out_channel),
    .out_seq     (out_seq),
    .out_payload (out_payload),
    .last        (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Outputs are checked before the request of the same edge is applied.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sb.check_result(kind, out_channel, out_seq, out_payload, last);
      if (start && !busy) sb.predict(mode, channel, seq, payload);
      if (cfg_valid && cfg_ready) sb.note_config(cfg_data);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_request(input logic m, input chan_t ch, input seq_t s, input pay_t p);
    int unsigned gap;
    gap = 0;
    if (gaps_on && gap_burst && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    mode    <= m;
    channel <= ch;
    seq     <= s;
    payload <= p;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  task automatic push(input chan_t ch, input seq_t s, input pay_t p);
    send_request(msa_pkg::MODE_PUSH, ch, s, p);
  endtask

  // channel, seq and payload are don't-care on a tick
  task automatic tick();
    send_request(msa_pkg::MODE_TICK, chan_t'($urandom_range(0, 7)), seq_t'($urandom), $urandom);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input count_t v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic seq_t near_frame();
    return seq_t'(frame_seq + $urandom_range(0, 4) - 2);
  endfunction

  // Mostly complete frames across the active channels followed by a tick;
  // the rest is stray pushes, stray ticks and bursts to one channel that can overflow its queue.
  task automatic run_phase(input count_t cc, input int unsigned budget);
    int unsigned lanes, sent, i, pick, burst;
    chan_t       target;
    lanes = (cc == 0) ? 1 : ((cc > msa_pkg::MAX_ACTIVE) ? msa_pkg::MAX_ACTIVE : 32'(cc));
    sent = 0;
    while (sent < budget) begin
      gap_burst = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 11);
      if (pick < 8) begin
        for (i = 0; i < lanes; i++) begin
          case ($urandom_range(0, 9))
            0: ;  // frame lost on this channel
            1: begin
              push(chan_t'(i), near_frame(), $urandom);
              sent++;
            end
            default: begin
              push(chan_t'(i), frame_seq, $urandom);
              sent++;
            end
          endcase
        end
        tick();
        sent++;
        frame_seq = frame_seq + seq_t'($urandom_range(1, 2));
      end else if (pick < 11) begin
        if ($urandom_range(0, 1) != 0) push(chan_t'($urandom_range(0, 7)), near_frame(), $urandom);
        else tick();
        sent++;
      end else begin
        target = chan_t'($urandom_range(0, 7));
        burst = $urandom_range(4, 20);
        repeat (burst) push(target, near_frame(), $urandom);
        sent += burst;
      end
      if ($urandom_range(0, 24) == 0) drain();
    end
  endtask

  initial begin : stimulus
    count_t plan [PHASE_COUNT];
    int     k;
    plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd8};
    plan[5] = count_t'($urandom_range(2, 7));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // two channels active out of reset
    tick();                                          // all queues empty
    push(3'd0, 31'd0, 32'h0000_0000);
    push(3'd1, 31'd0, 32'hFFFF_FFFF);
    tick();                                          // equal heads
    push(3'd0, 31'h7FFF_FFFF, 32'hA5A5_A5A5);
    push(3'd1, 31'd1, 32'h5A5A_5A5A);
    tick();                                          // ch1 behind, dropped
    push(3'd1, 31'h7FFF_FFFF, 32'h0000_0001);
    tick();
    push(3'd0, 31'd10, $urandom);
    push(3'd1, 31'd30, $urandom);
    tick();                                          // ch1 ahead, ch0 dropped
    push(3'd0, 31'd30, $urandom);
    tick();
    push(3'd7, 31'd123, $urandom);                   // inactive channel holds it
    drain();

    write_count(4'd4);
    push(3'd0, 31'd100, $urandom);
    push(3'd1, 31'd200, $urandom);
    push(3'd2, 31'd50, $urandom);
    push(3'd3, 31'd900, $urandom);
    tick();                                          // scan stops at ch2, bound from ch1
    push(3'd0, 31'd200, $urandom);
    push(3'd2, 31'd200, $urandom);
    tick();
    drain();

    for (k = 0; k < PHASE_COUNT; k++) begin
      write_count(plan[k]);
      gaps_on = (k != PHASE_COUNT - 1);
      if (k == PHASE_COUNT - 1) frame_seq = 31'h7FFF_F000;
      else frame_seq = frame_seq + seq_t'($urandom_range(1, 1 << 24));
      run_phase(plan[k], PHASE_REQUESTS);
      drain();
    end

    sb.close_out();
    $display("run: %0d requests, %0d outputs checked, %0d bundles, %0d overflow notices",
             requests_sent, sb.checked, sb.bundles, sb.notices);
    $display("camera counts: reset 2, then 4, 1, 8, 0, 15, 3, %0d, 8", plan[5]);
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/msa_pkg.sv
rtl/msa_ram.sv
rtl/msa_front.sv
rtl/msa_back.sv
rtl/multi_channel_sequence_aligner_core.sv
test/tb_multi_channel_sequence_aligner_core.sv
